### hdl/affine_matrix_to_trs_decompose_core_assert.svh
// assertion macros for the trs decomposition core checker
// relies on clock and reset being visible in the scope of use
`ifndef AFFINE_MATRIX_TO_TRS_DECOMPOSE_CORE_ASSERT_SVH
`define AFFINE_MATRIX_TO_TRS_DECOMPOSE_CORE_ASSERT_SVH

// implication checked on every edge outside reset
`define AMTD_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication check failed");

// condition that holds on every edge outside reset
`define AMTD_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("invariant check failed");

`endif

### hdl/amtd_pkg.sv
// shared types and constants for the trs decomposition core
// no dependencies
package amtd_pkg;

   localparam int SQRT_STAGES = 32;   // one root bit per stage, 64-bit radicand
   localparam int DIV_STAGES  = 31;   // one quotient bit per stage, quotient <= 2^30

   localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

   typedef struct packed {
      logic signed [31:0] m00;
      logic signed [31:0] m01;
      logic signed [31:0] m02;
      logic signed [31:0] m03;
      logic signed [31:0] m10;
      logic signed [31:0] m11;
      logic signed [31:0] m12;
      logic signed [31:0] m13;
      logic signed [31:0] m20;
      logic signed [31:0] m21;
      logic signed [31:0] m22;
      logic signed [31:0] m23;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [30:0]        scale_x;
      logic [30:0]        scale_y;
      logic [30:0]        scale_z;
      logic signed [31:0] quat_x;
      logic signed [31:0] quat_y;
      logic signed [31:0] quat_z;
      logic signed [31:0] quat_w;
      logic               degenerate;
   } rsp_type;

endpackage

### hdl/amtd_sqrt.sv
// pipelined integer square root, floor(sqrt(x)) of a 64-bit radicand
// depends on amtd_pkg for the stage count
module amtd_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [63:0] in_radicand,
   output logic        out_valid,
   output logic [31:0] out_root
);

   localparam int N = amtd_pkg::SQRT_STAGES;

   logic [N-1:0] valid_ff, valid_in;
   logic [63:0]  rad_ff  [0:N-1];
   logic [33:0]  rem_ff  [0:N-1];
   logic [31:0]  root_ff [0:N-1];
   logic [63:0]  rad_in  [0:N-1];
   logic [33:0]  rem_in  [0:N-1];
   logic [31:0]  root_in [0:N-1];

   logic [63:0]  cur_rad  [0:N-1];
   logic [33:0]  cur_rem  [0:N-1];
   logic [31:0]  cur_root [0:N-1];
   logic [N-1:0] cur_valid;
   logic [35:0]  rem_sh   [0:N-1];
   logic [35:0]  trial    [0:N-1];
   logic [35:0]  rem_sub  [0:N-1];
   logic [N-1:0] ge;

   always_comb begin
      cur_rad[0]   = in_radicand;
      cur_rem[0]   = '0;
      cur_root[0]  = '0;
      cur_valid[0] = in_valid;
      for (int k = 1; k < N; k++) begin
         cur_rad[k]   = rad_ff[k-1];
         cur_rem[k]   = rem_ff[k-1];
         cur_root[k]  = root_ff[k-1];
         cur_valid[k] = valid_ff[k-1];
      end
      for (int k = 0; k < N; k++) begin
         // bring down the next radicand digit pair, try root*4+1
         rem_sh[k]  = {cur_rem[k], cur_rad[k][63:62]};
         trial[k]   = {2'b00, cur_root[k], 2'b01};
         ge[k]      = (rem_sh[k] >= trial[k]);
         rem_sub[k] = ge[k] ? (rem_sh[k] - trial[k]) : rem_sh[k];
         rem_in[k]  = rem_sub[k][33:0];
         root_in[k] = {cur_root[k][30:0], ge[k]};
         rad_in[k]  = {cur_rad[k][61:0], 2'b00};
         valid_in[k] = cur_valid[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      for (int k = 0; k < N; k++) begin
         rad_ff[k]  <= rad_in[k];
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_root  = root_ff[N-1];

endmodule

### hdl/amtd_div.sv
// pipelined signed fraction divider, sign * (mag * 2^30 / den), truncated
// needs mag <= den so the quotient stays within 2^30; depends on amtd_pkg
module amtd_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [31:0]        in_mag,
   input  logic [31:0]        in_den,
   input  logic               in_neg,
   output logic               out_valid,
   output logic signed [31:0] out_quot
);

   localparam int N = amtd_pkg::DIV_STAGES;

   logic [N-1:0] valid_ff, valid_in;
   logic [N-1:0] neg_ff, neg_in;
   logic [31:0]  den_ff [0:N-1];
   logic [31:0]  rem_ff [0:N-1];
   logic [30:0]  quo_ff [0:N-1];
   logic [31:0]  den_in [0:N-1];
   logic [31:0]  rem_in [0:N-1];
   logic [30:0]  quo_in [0:N-1];

   logic [31:0]  cur_den [0:N-1];
   logic [31:0]  cur_rem [0:N-1];
   logic [30:0]  cur_quo [0:N-1];
   logic [N-1:0] cur_valid, cur_neg, cur_bit, ge;
   logic [32:0]  rem_sh  [0:N-1];
   logic [32:0]  rem_sub [0:N-1];
   logic [31:0]  quo_ext;

   always_comb begin
      // dividend is mag shifted up by 30: mag's lowest bit enters at stage 0, zeros after it
      cur_den[0]   = in_den;
      cur_rem[0]   = {1'b0, in_mag[31:1]};
      cur_quo[0]   = '0;
      cur_valid[0] = in_valid;
      cur_neg[0]   = in_neg;
      cur_bit[0]   = in_mag[0];
      for (int k = 1; k < N; k++) begin
         cur_den[k]   = den_ff[k-1];
         cur_rem[k]   = rem_ff[k-1];
         cur_quo[k]   = quo_ff[k-1];
         cur_valid[k] = valid_ff[k-1];
         cur_neg[k]   = neg_ff[k-1];
         cur_bit[k]   = 1'b0;
      end
      for (int k = 0; k < N; k++) begin
         rem_sh[k]  = {cur_rem[k], cur_bit[k]};
         ge[k]      = (rem_sh[k] >= {1'b0, cur_den[k]});
         rem_sub[k] = ge[k] ? (rem_sh[k] - {1'b0, cur_den[k]}) : rem_sh[k];
         rem_in[k]  = rem_sub[k][31:0];
         quo_in[k]  = {cur_quo[k][29:0], ge[k]};
         den_in[k]  = cur_den[k];
         neg_in[k]  = cur_neg[k];
         valid_in[k] = cur_valid[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      neg_ff <= neg_in;
      for (int k = 0; k < N; k++) begin
         den_ff[k] <= den_in[k];
         rem_ff[k] <= rem_in[k];
         quo_ff[k] <= quo_in[k];
      end
   end

   assign quo_ext   = {1'b0, quo_ff[N-1]};
   assign out_valid = valid_ff[N-1];
   assign out_quot  = neg_ff[N-1] ? $signed(-quo_ext) : $signed(quo_ext);

endmodule

### hdl/affine_matrix_to_trs_decompose_core.sv
// trs decomposition core: affine 3x4 to translation, column scales, unit quaternion
// the request is registered at the accepting edge and the result strobe is driven by the result
// register; 136 register stages, most of them in two 32-stage square roots
// and two 31-stage dividers in series; one transaction per cycle, no stalls
// busy is high only during reset; synchronous reset empties the pipeline
// depends on amtd_pkg, amtd_sqrt and amtd_div
module affine_matrix_to_trs_decompose_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  amtd_pkg::req_type req_data,
   output logic              rsp_strobe,
   output amtd_pkg::rsp_type rsp_data
);

   localparam int SQ = amtd_pkg::SQRT_STAGES;
   localparam int DV = amtd_pkg::DIV_STAGES;

   // quaternion branch codes
   localparam logic [1:0] BR_TRACE = 2'd0;
   localparam logic [1:0] BR_X     = 2'd1;
   localparam logic [1:0] BR_Y     = 2'd2;
   localparam logic [1:0] BR_Z     = 2'd3;

   // data that rides alongside the arithmetic
   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [30:0]        scale_x;
      logic [30:0]        scale_y;
      logic [30:0]        scale_z;
      logic               degen;
   } side_type;

   typedef struct packed {
      side_type          side;
      logic [3:0][30:0]  mag;
      logic [3:0]        neg;
   } qside_type;

   typedef struct packed {
      side_type side;
      logic     ident;
   } qfin_type;

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      logic [31:0] u;
      u = v;
      return v[31] ? (32'd0 - u) : u;
   endfunction

   // negative dominant term clamps to zero
   function automatic logic signed [33:0] clamp0(input logic signed [33:0] v);
      return v[33] ? 34'sd0 : v;
   endfunction

   // shift right by two, truncating toward zero
   function automatic logic signed [31:0] shr2(input logic signed [33:0] v);
      logic [33:0] m;
      logic [31:0] s;
      m = v[33] ? (34'd0 - v) : v;
      s = 32'(m >> 2);
      return v[33] ? $signed(32'd0 - s) : $signed(s);
   endfunction

   // never holds a transaction off outside reset
   assign busy = reset;

   // ---------------- input register
   amtd_pkg::req_type in_ff;
   logic              in_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= start && !busy;
      end
      in_ff <= req_data;
   end

   logic signed [31:0] in_m [0:2][0:2];
   always_comb begin
      in_m[0][0] = in_ff.m00; in_m[0][1] = in_ff.m01; in_m[0][2] = in_ff.m02;
      in_m[1][0] = in_ff.m10; in_m[1][1] = in_ff.m11; in_m[1][2] = in_ff.m12;
      in_m[2][0] = in_ff.m20; in_m[2][1] = in_ff.m21; in_m[2][2] = in_ff.m22;
   end

   // ---------------- squares of the rotation-scale elements
   logic [63:0]       sq_ff [0:2][0:2];
   amtd_pkg::req_type req1_ff;
   logic              vld1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else begin
         vld1_ff <= in_vld_ff;
      end
      req1_ff <= in_ff;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            sq_ff[i][j] <= mag32(in_m[i][j]) * mag32(in_m[i][j]);
         end
      end
   end

   // ---------------- column sums (at most 3 * 2^62, fits 64 bits)
   logic [63:0]       colsum_ff [0:2];
   amtd_pkg::req_type req2_ff;
   logic              vld2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff <= 1'b0;
      end else begin
         vld2_ff <= vld1_ff;
      end
      req2_ff <= req1_ff;
      for (int j = 0; j < 3; j++) begin
         colsum_ff[j] <= sq_ff[0][j] + sq_ff[1][j] + sq_ff[2][j];
      end
   end

   // ---------------- column lengths
   logic [31:0] col_root [0:2];
   logic [2:0]  col_vld;

   genvar gi, gj;
   generate
      for (gj = 0; gj < 3; gj++) begin : g_col_sqrt
         amtd_sqrt u_sqrt (
            .clock       (clock),
            .reset       (reset),
            .in_valid    (vld2_ff),
            .in_radicand (colsum_ff[gj]),
            .out_valid   (col_vld[gj]),
            .out_root    (col_root[gj])
         );
      end
   endgenerate

   amtd_pkg::req_type req_dly_ff [0:SQ-1];
   always_ff @(posedge clock) begin
      req_dly_ff[0] <= req2_ff;
      for (int k = 1; k < SQ; k++) begin
         req_dly_ff[k] <= req_dly_ff[k-1];
      end
   end

   logic signed [31:0] dl_m [0:2][0:2];
   always_comb begin
      dl_m[0][0] = req_dly_ff[SQ-1].m00;
      dl_m[0][1] = req_dly_ff[SQ-1].m01;
      dl_m[0][2] = req_dly_ff[SQ-1].m02;
      dl_m[1][0] = req_dly_ff[SQ-1].m10;
      dl_m[1][1] = req_dly_ff[SQ-1].m11;
      dl_m[1][2] = req_dly_ff[SQ-1].m12;
      dl_m[2][0] = req_dly_ff[SQ-1].m20;
      dl_m[2][1] = req_dly_ff[SQ-1].m21;
      dl_m[2][2] = req_dly_ff[SQ-1].m22;
   end

   // saturate a root to the 31-bit scale field
   function automatic logic [30:0] sat31(input logic [31:0] v);
      return v[31] ? 31'h7FFF_FFFF : v[30:0];
   endfunction

   // ---------------- divider operand register
   logic [31:0] dmag_ff  [0:2][0:2];
   logic        dneg_ff  [0:2][0:2];
   logic [31:0] sroot_ff [0:2];
   side_type    pd_side_ff;
   logic        pd_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pd_vld_ff <= 1'b0;
      end else begin
         pd_vld_ff <= &col_vld;
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            dmag_ff[i][j] <= mag32(dl_m[i][j]);
            dneg_ff[i][j] <= dl_m[i][j][31];
         end
      end
      for (int j = 0; j < 3; j++) begin
         sroot_ff[j] <= col_root[j];
      end
      pd_side_ff.pos_x   <= req_dly_ff[SQ-1].m03;
      pd_side_ff.pos_y   <= req_dly_ff[SQ-1].m13;
      pd_side_ff.pos_z   <= req_dly_ff[SQ-1].m23;
      pd_side_ff.scale_x <= sat31(col_root[0]);
      pd_side_ff.scale_y <= sat31(col_root[1]);
      pd_side_ff.scale_z <= sat31(col_root[2]);
      pd_side_ff.degen   <= (col_root[0] == '0) || (col_root[1] == '0) ||
                            (col_root[2] == '0);
   end

   // ---------------- rotation elements, Q2.30
   logic signed [31:0] r_q  [0:2][0:2];
   logic [8:0]         r_vld;

   generate
      for (gi = 0; gi < 3; gi++) begin : g_row_div
         for (gj = 0; gj < 3; gj++) begin : g_col_div
            amtd_div u_div (
               .clock     (clock),
               .reset     (reset),
               .in_valid  (pd_vld_ff),
               .in_mag    (dmag_ff[gi][gj]),
               .in_den    (sroot_ff[gj]),
               .in_neg    (dneg_ff[gi][gj]),
               .out_valid (r_vld[gi*3+gj]),
               .out_quot  (r_q[gi][gj])
            );
         end
      end
   endgenerate

   side_type side_dly_ff [0:DV-1];
   always_ff @(posedge clock) begin
      side_dly_ff[0] <= pd_side_ff;
      for (int k = 1; k < DV; k++) begin
         side_dly_ff[k] <= side_dly_ff[k-1];
      end
   end

   // ---------------- trace, dominant terms, sums and differences
   logic signed [33:0] r00, r01, r02, r10, r11, r12, r20, r21, r22, one34, tr_in;
   logic [1:0]         br_in;

   always_comb begin
      r00 = 34'(r_q[0][0]); r01 = 34'(r_q[0][1]); r02 = 34'(r_q[0][2]);
      r10 = 34'(r_q[1][0]); r11 = 34'(r_q[1][1]); r12 = 34'(r_q[1][2]);
      r20 = 34'(r_q[2][0]); r21 = 34'(r_q[2][1]); r22 = 34'(r_q[2][2]);
      one34 = 34'(amtd_pkg::ONE_Q30);
      tr_in = r00 + r11 + r22;
      if (tr_in > 34'sd0) begin
         br_in = BR_TRACE;
      end else if (r_q[0][0] > r_q[1][1] && r_q[0][0] > r_q[2][2]) begin
         br_in = BR_X;
      end else if (r_q[1][1] > r_q[2][2]) begin
         br_in = BR_Y;
      end else begin
         br_in = BR_Z;
      end
   end

   logic signed [33:0] tw_ff, d0_ff, d1_ff, d2_ff;
   logic signed [33:0] dfx_ff, dfy_ff, dfz_ff, smxy_ff, smxz_ff, smyz_ff;
   logic [1:0]         br_ff;
   side_type           t1_side_ff;
   logic               t1_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_vld_ff <= 1'b0;
      end else begin
         t1_vld_ff <= &r_vld;
      end
      tw_ff   <= tr_in + one34;
      d0_ff   <= one34 + r00 - r11 - r22;
      d1_ff   <= one34 + r11 - r00 - r22;
      d2_ff   <= one34 + r22 - r00 - r11;
      dfx_ff  <= r21 - r12;
      dfy_ff  <= r02 - r20;
      dfz_ff  <= r10 - r01;
      smxy_ff <= r01 + r10;
      smxz_ff <= r02 + r20;
      smyz_ff <= r12 + r21;
      br_ff   <= br_in;
      t1_side_ff <= side_dly_ff[DV-1];
   end

   // ---------------- branch select and shift; components x, y, z, w
   logic signed [33:0] sel [0:3];

   always_comb begin
      case (br_ff)
         BR_TRACE: begin
            sel[0] = dfx_ff;  sel[1] = dfy_ff;  sel[2] = dfz_ff;  sel[3] = tw_ff;
         end
         BR_X: begin
            sel[0] = clamp0(d0_ff); sel[1] = smxy_ff; sel[2] = smxz_ff; sel[3] = dfx_ff;
         end
         BR_Y: begin
            sel[0] = smxy_ff; sel[1] = clamp0(d1_ff); sel[2] = smyz_ff; sel[3] = dfy_ff;
         end
         default: begin
            sel[0] = smxz_ff; sel[1] = smyz_ff; sel[2] = clamp0(d2_ff); sel[3] = dfz_ff;
         end
      endcase
   end

   logic signed [31:0] c_ff [0:3];
   side_type           t2_side_ff;
   logic               t2_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t2_vld_ff <= 1'b0;
      end else begin
         t2_vld_ff <= t1_vld_ff;
      end
      for (int q = 0; q < 4; q++) begin
         c_ff[q] <= shr2(sel[q]);
      end
      t2_side_ff <= t1_side_ff;
   end

   // ---------------- component squares (magnitudes at most 2^30)
   logic [31:0] cmag_w [0:3];
   always_comb begin
      for (int q = 0; q < 4; q++) begin
         cmag_w[q] = mag32(c_ff[q]);
      end
   end

   logic [61:0] csq_ff  [0:3];
   logic [30:0] cmag_ff [0:3];
   logic [3:0]  cneg_ff;
   side_type    t3_side_ff;
   logic        t3_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t3_vld_ff <= 1'b0;
      end else begin
         t3_vld_ff <= t2_vld_ff;
      end
      for (int q = 0; q < 4; q++) begin
         csq_ff[q]  <= cmag_w[q][30:0] * cmag_w[q][30:0];
         cmag_ff[q] <= cmag_w[q][30:0];
         cneg_ff[q] <= c_ff[q][31];
      end
      t3_side_ff <= t2_side_ff;
   end

   // ---------------- sum of squares
   logic [63:0] ss_ff;
   qside_type   t4_ff;
   logic        t4_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t4_vld_ff <= 1'b0;
      end else begin
         t4_vld_ff <= t3_vld_ff;
      end
      ss_ff <= 64'(csq_ff[0]) + 64'(csq_ff[1]) + 64'(csq_ff[2]) + 64'(csq_ff[3]);
      t4_ff.side <= t3_side_ff;
      for (int q = 0; q < 4; q++) begin
         t4_ff.mag[q] <= cmag_ff[q];
      end
      t4_ff.neg <= cneg_ff;
   end

   // ---------------- quaternion norm
   logic        n_vld;
   logic [31:0] n_root;

   amtd_sqrt u_norm_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (t4_vld_ff),
      .in_radicand (ss_ff),
      .out_valid   (n_vld),
      .out_root    (n_root)
   );

   qside_type qs_dly_ff [0:SQ-1];
   always_ff @(posedge clock) begin
      qs_dly_ff[0] <= t4_ff;
      for (int k = 1; k < SQ; k++) begin
         qs_dly_ff[k] <= qs_dly_ff[k-1];
      end
   end

   // ---------------- normalise operand register
   logic [31:0] nroot_ff;
   qside_type   qn_ff;
   qfin_type    qn_fin_ff;
   logic        qn_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         qn_vld_ff <= 1'b0;
      end else begin
         qn_vld_ff <= n_vld;
      end
      nroot_ff        <= n_root;
      qn_ff           <= qs_dly_ff[SQ-1];
      qn_fin_ff.side  <= qs_dly_ff[SQ-1].side;
      // zero scale or vanishing vector both give the identity
      qn_fin_ff.ident <= qs_dly_ff[SQ-1].side.degen || (n_root == '0);
   end

   logic signed [31:0] qo   [0:3];
   logic [3:0]         qo_vld;

   generate
      for (gi = 0; gi < 4; gi++) begin : g_norm_div
         amtd_div u_div (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (qn_vld_ff),
            .in_mag    ({1'b0, qn_ff.mag[gi]}),
            .in_den    (nroot_ff),
            .in_neg    (qn_ff.neg[gi]),
            .out_valid (qo_vld[gi]),
            .out_quot  (qo[gi])
         );
      end
   endgenerate

   qfin_type fin_dly_ff [0:DV-1];
   always_ff @(posedge clock) begin
      fin_dly_ff[0] <= qn_fin_ff;
      for (int k = 1; k < DV; k++) begin
         fin_dly_ff[k] <= fin_dly_ff[k-1];
      end
   end

   // ---------------- result register
   amtd_pkg::rsp_type rsp_ff;
   logic              rsp_vld_ff;
   qfin_type          fin_w;

   assign fin_w = fin_dly_ff[DV-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= &qo_vld;
      end
      rsp_ff.pos_x      <= fin_w.side.pos_x;
      rsp_ff.pos_y      <= fin_w.side.pos_y;
      rsp_ff.pos_z      <= fin_w.side.pos_z;
      rsp_ff.scale_x    <= fin_w.side.scale_x;
      rsp_ff.scale_y    <= fin_w.side.scale_y;
      rsp_ff.scale_z    <= fin_w.side.scale_z;
      rsp_ff.degenerate <= fin_w.side.degen;
      if (fin_w.ident) begin
         rsp_ff.quat_x <= '0;
         rsp_ff.quat_y <= '0;
         rsp_ff.quat_z <= '0;
         rsp_ff.quat_w <= amtd_pkg::ONE_Q30;
      end else begin
         rsp_ff.quat_x <= qo[0];
         rsp_ff.quat_y <= qo[1];
         rsp_ff.quat_z <= qo[2];
         rsp_ff.quat_w <= qo[3];
      end
   end

   assign rsp_strobe = rsp_vld_ff;
   assign rsp_data   = rsp_ff;

endmodule

### hdl/amtd_checker.sv
// port-level checks for the trs decomposition core, bound to the top level
// depends on amtd_pkg and the assertion macro header
`include "affine_matrix_to_trs_decompose_core_assert.svh"

module amtd_checker (
   input logic              clock,
   input logic              reset,
   input logic              busy,
   input logic              rsp_strobe,
   input amtd_pkg::rsp_type rsp_data
);

   // a zero column length and the degenerate flag go together
   `AMTD_ASSERT_IMPL(a_degen_scale, rsp_strobe, rsp_data.degenerate == ((rsp_data.scale_x == '0) || (rsp_data.scale_y == '0) || (rsp_data.scale_z == '0)))

   // degenerate transactions carry the identity rotation
   `AMTD_ASSERT_IMPL(a_degen_ident, rsp_strobe && rsp_data.degenerate, (rsp_data.quat_x == '0) && (rsp_data.quat_y == '0) && (rsp_data.quat_z == '0) && (rsp_data.quat_w == amtd_pkg::ONE_Q30))

   // the x and w quaternion components never exceed one in magnitude
   `AMTD_ASSERT_IMPL(a_quat_range, rsp_strobe, (rsp_data.quat_x <= amtd_pkg::ONE_Q30) && (rsp_data.quat_x >= -amtd_pkg::ONE_Q30) && (rsp_data.quat_w <= amtd_pkg::ONE_Q30) && (rsp_data.quat_w >= -amtd_pkg::ONE_Q30))

   // fully pipelined: never holds off a transaction outside reset
   `AMTD_ASSERT_ALWAYS(a_never_busy, !busy)

endmodule

bind affine_matrix_to_trs_decompose_core amtd_checker u_amtd_checker (
   .clock      (clock),
   .reset      (reset),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
